### src/amg_pkg.sv
`default_nettype none

package amg_pkg;

  localparam int VERTEX_SLOTS = 64;
  localparam int EDGE_SLOTS   = 32;
  localparam int LABEL_WIDTH  = 64;

  localparam int VIDX_W = 6;
  localparam int ROWS   = 1 << VIDX_W;
  localparam int ENDS_W = 2 * VIDX_W;
  localparam int CNT_W  = 6;
  localparam int VCNT_W = 7;
  localparam int EIDX_W = (EDGE_SLOTS > 1) ? $clog2(EDGE_SLOTS) : 1;

  typedef logic [ROWS-1:0] row_t;

  typedef enum logic [1:0] {
    OP_INS_VERTEX = 2'd0,
    OP_INS_EDGE   = 2'd1,
    OP_ERASE      = 2'd2,
    OP_REPORT     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ERROR  = 2'd0,
    KIND_COUNTS = 2'd1,
    KIND_EDGES  = 2'd2,
    KIND_LABEL  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_CHK,
    ST_EDGE_WRB,
    ST_ER_EXAM,
    ST_ER_CLR,
    ST_ER_DONE,
    ST_EM_OUT
  } state_t;

  typedef struct packed {
    logic              we;
    logic [VIDX_W-1:0] waddr;
    row_t              wdata;
    logic [VIDX_W-1:0] raddr;
    logic              clr;
    logic [VIDX_W-1:0] caddr;
  } adj_req_t;

  typedef struct packed {
    logic                   we;
    logic [EIDX_W-1:0]      waddr;
    logic [LABEL_WIDTH-1:0] wlabel;
    logic [ENDS_W-1:0]      wends;
    logic [EIDX_W-1:0]      raddr;
  } edge_req_t;

endpackage

`default_nettype wire

### src/amg_adj_mem.sv
`default_nettype none

module amg_adj_mem (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire amg_pkg::adj_req_t           req,
  output      amg_pkg::row_t               rdata
);

  amg_pkg::row_t               mem [amg_pkg::ROWS];
  logic [amg_pkg::ROWS-1:0]    valid;
  amg_pkg::row_t               rd_q;
  logic                        vld_q;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_q <= mem[req.raddr];
  end

  // row valid bits, an invalid row reads as all zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vld_q <= 1'b0;
    end else begin
      if (req.we) begin
        valid[req.waddr] <= 1'b1;
      end
      if (req.clr) begin
        valid[req.caddr] <= 1'b0;
      end
      vld_q <= valid[req.raddr];
    end
  end

  assign rdata = vld_q ? rd_q : '0;

endmodule

`default_nettype wire

### src/amg_edge_mem.sv
`default_nettype none

module amg_edge_mem (
  input  wire logic                            clk,
  input  wire amg_pkg::edge_req_t              req,
  output      logic [amg_pkg::LABEL_WIDTH-1:0] rd_label,
  output      logic [amg_pkg::ENDS_W-1:0]      rd_ends
);

  logic [amg_pkg::LABEL_WIDTH-1:0] mem_label [amg_pkg::EDGE_SLOTS];
  logic [amg_pkg::ENDS_W-1:0]      mem_ends  [amg_pkg::EDGE_SLOTS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_label[req.waddr] <= req.wlabel;
      mem_ends[req.waddr]  <= req.wends;
    end
    rd_label <= mem_label[req.raddr];
    rd_ends  <= mem_ends[req.raddr];
  end

endmodule

`default_nettype wire

### src/adjacency_matrix_graph_store_core.sv
`default_nettype none

// undirected graph store: vertex present bits, a symmetric adjacency bit
// matrix in a row memory and an insertion-ordered edge list with labels
//
// command channel: an item (operation, vertex_a, vertex_b, edge_label) is
// taken at a rising edge with start high and busy low
// result channel: each result shows for one cycle with strobe high; the
// receiver cannot stall, so results stream out at the rate they are made
//
// work per item:
//   insert vertex, report: done at the command edge (result on the next
//   cycle); insert edge: ends there on a missing end or a full list,
//   after the row a read on an existing edge or a self loop, else reads
//   row a, updates it, then row b; erase vertex: walks the stored edges,
//   clears mirror bits, then streams surviving labels one per cycle
// errors are found at the command edge or after the row read
// reset clears present bits, counts and the row valid bits at once; the
// edge list memory needs no clearing since only entries below the count
// are ever read
module adjacency_matrix_graph_store_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output      logic                            busy,
  input  wire logic [1:0]                      operation,
  input  wire logic [5:0]                      vertex_a,
  input  wire logic [5:0]                      vertex_b,
  input  wire logic [63:0]                     edge_label,
  output      logic                            strobe,
  output      logic [1:0]                      kind,
  output      logic [6:0]                      vertex_total,
  output      logic [5:0]                      edge_total,
  output      logic [63:0]                     label_out,
  output      logic                            last
);

  amg_pkg::state_t                  state, state_next;
  amg_pkg::row_t                    present, present_next;
  logic [amg_pkg::VCNT_W-1:0]       vcount, vcount_next;
  logic [amg_pkg::CNT_W-1:0]        ecount, ecount_next;
  logic [amg_pkg::CNT_W-1:0]        scan, scan_next;
  logic [amg_pkg::CNT_W-1:0]        keep, keep_next;
  logic [amg_pkg::VIDX_W-1:0]       other, other_next;

  // captured command
  logic [amg_pkg::VIDX_W-1:0]       cur_a, cur_b;
  logic [amg_pkg::LABEL_WIDTH-1:0]  cur_label;

  amg_pkg::adj_req_t                adj_req;
  amg_pkg::row_t                    adj_rdata;
  amg_pkg::edge_req_t               edge_req;
  logic [amg_pkg::LABEL_WIDTH-1:0]  edge_rd_label;
  logic [amg_pkg::ENDS_W-1:0]       edge_rd_ends;

  // result being formed this cycle
  logic                             res_fire;
  amg_pkg::kind_t                   res_kind;
  logic [amg_pkg::VCNT_W-1:0]       res_vtotal;
  logic [amg_pkg::CNT_W-1:0]        res_etotal;
  logic [amg_pkg::LABEL_WIDTH-1:0]  res_label;
  logic                             res_last;

  // registered result
  amg_pkg::kind_t                   out_kind;
  logic [amg_pkg::LABEL_WIDTH-1:0]  out_label;

  logic                             accept;
  logic                             scan_last;
  logic [amg_pkg::VIDX_W-1:0]       end_s, end_d, end_other;
  logic                             end_hit;

  function automatic logic has_vertex(input amg_pkg::row_t pres,
                                      input logic [amg_pkg::VIDX_W-1:0] v);
    return (32'(v) < amg_pkg::VERTEX_SLOTS) && pres[v];
  endfunction

  amg_adj_mem u_adj (
    .clk   (clk),
    .rst   (rst),
    .req   (adj_req),
    .rdata (adj_rdata)
  );

  amg_edge_mem u_edge (
    .clk      (clk),
    .req      (edge_req),
    .rd_label (edge_rd_label),
    .rd_ends  (edge_rd_ends)
  );

  assign busy   = (state != amg_pkg::ST_IDLE);
  assign accept = start && !busy;

  // scan position is the final entry of the list
  assign scan_last = ((scan + amg_pkg::CNT_W'(1)) == ecount);

  // ends of the list entry read in the previous cycle
  assign end_s     = edge_rd_ends[amg_pkg::ENDS_W-1:amg_pkg::VIDX_W];
  assign end_d     = edge_rd_ends[amg_pkg::VIDX_W-1:0];
  assign end_hit   = (end_s == cur_a) || (end_d == cur_a);
  assign end_other = (end_s == cur_a) ? end_d : end_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= amg_pkg::ST_IDLE;
      present <= '0;
      vcount  <= '0;
      ecount  <= '0;
      scan    <= '0;
      keep    <= '0;
      other   <= '0;
    end else begin
      state   <= state_next;
      present <= present_next;
      vcount  <= vcount_next;
      ecount  <= ecount_next;
      scan    <= scan_next;
      keep    <= keep_next;
      other   <= other_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_a     <= vertex_a;
      cur_b     <= vertex_b;
      cur_label <= edge_label[amg_pkg::LABEL_WIDTH-1:0];
    end
  end

  always_comb begin
    state_next   = state;
    present_next = present;
    vcount_next  = vcount;
    ecount_next  = ecount;
    scan_next    = scan;
    keep_next    = keep;
    other_next   = other;
    adj_req      = '0;
    edge_req     = '0;
    res_fire     = 1'b0;
    res_kind     = amg_pkg::KIND_ERROR;
    res_vtotal   = '0;
    res_etotal   = '0;
    res_label    = '0;
    res_last     = 1'b0;

    unique case (state)
      amg_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (amg_pkg::op_t'(operation))
            amg_pkg::OP_INS_VERTEX: begin
              if ((32'(vertex_a) < amg_pkg::VERTEX_SLOTS) && !present[vertex_a]) begin
                present_next[vertex_a] = 1'b1;
                vcount_next            = vcount + amg_pkg::VCNT_W'(1);
              end
            end
            amg_pkg::OP_INS_EDGE: begin
              if (!has_vertex(present, vertex_a) || !has_vertex(present, vertex_b) ||
                  (32'(ecount) >= amg_pkg::EDGE_SLOTS)) begin
                res_fire = 1'b1;
                res_last = 1'b1;
              end else begin
                // fetch row a to test for an existing edge
                adj_req.raddr = vertex_a;
                state_next    = amg_pkg::ST_EDGE_CHK;
              end
            end
            amg_pkg::OP_ERASE: begin
              scan_next = '0;
              keep_next = '0;
              if (!has_vertex(present, vertex_a)) begin
                res_fire = 1'b1;
                res_last = 1'b1;
              end else if (ecount == '0) begin
                state_next = amg_pkg::ST_ER_DONE;
              end else begin
                edge_req.raddr = '0;
                state_next     = amg_pkg::ST_ER_EXAM;
              end
            end
            amg_pkg::OP_REPORT: begin
              res_fire   = 1'b1;
              res_kind   = amg_pkg::KIND_COUNTS;
              res_vtotal = vcount;
              res_etotal = ecount;
              res_last   = 1'b1;
            end
            default: ;
          endcase
        end
      end

      amg_pkg::ST_EDGE_CHK: begin
        if (adj_rdata[cur_b]) begin
          res_fire   = 1'b1;
          res_last   = 1'b1;
          state_next = amg_pkg::ST_IDLE;
        end else begin
          adj_req.we      = 1'b1;
          adj_req.waddr   = cur_a;
          adj_req.wdata   = adj_rdata | (amg_pkg::row_t'(1) << cur_b);
          edge_req.we     = 1'b1;
          edge_req.waddr  = ecount[amg_pkg::EIDX_W-1:0];
          edge_req.wlabel = cur_label;
          edge_req.wends  = {cur_a, cur_b};
          ecount_next     = ecount + amg_pkg::CNT_W'(1);
          // a self loop lives in one row only
          if (cur_a == cur_b) begin
            state_next = amg_pkg::ST_IDLE;
          end else begin
            adj_req.raddr = cur_b;
            state_next    = amg_pkg::ST_EDGE_WRB;
          end
        end
      end

      amg_pkg::ST_EDGE_WRB: begin
        adj_req.we    = 1'b1;
        adj_req.waddr = cur_b;
        adj_req.wdata = adj_rdata | (amg_pkg::row_t'(1) << cur_a);
        state_next    = amg_pkg::ST_IDLE;
      end

      amg_pkg::ST_ER_EXAM: begin
        if (end_hit && (end_other != cur_a)) begin
          // clear the mirror bit in the other end's row
          adj_req.raddr = end_other;
          other_next    = end_other;
          state_next    = amg_pkg::ST_ER_CLR;
        end else begin
          if (!end_hit) begin
            edge_req.we     = 1'b1;
            edge_req.waddr  = keep[amg_pkg::EIDX_W-1:0];
            edge_req.wlabel = edge_rd_label;
            edge_req.wends  = edge_rd_ends;
            keep_next       = keep + amg_pkg::CNT_W'(1);
          end
          if (scan_last) begin
            state_next = amg_pkg::ST_ER_DONE;
          end else begin
            scan_next      = scan + amg_pkg::CNT_W'(1);
            edge_req.raddr = scan_next[amg_pkg::EIDX_W-1:0];
          end
        end
      end

      amg_pkg::ST_ER_CLR: begin
        adj_req.we    = 1'b1;
        adj_req.waddr = other;
        adj_req.wdata = adj_rdata & ~(amg_pkg::row_t'(1) << cur_a);
        if (scan_last) begin
          state_next = amg_pkg::ST_ER_DONE;
        end else begin
          scan_next      = scan + amg_pkg::CNT_W'(1);
          edge_req.raddr = scan_next[amg_pkg::EIDX_W-1:0];
          state_next     = amg_pkg::ST_ER_EXAM;
        end
      end

      amg_pkg::ST_ER_DONE: begin
        ecount_next           = keep;
        present_next[cur_a]   = 1'b0;
        vcount_next           = vcount - amg_pkg::VCNT_W'(1);
        adj_req.clr           = 1'b1;
        adj_req.caddr         = cur_a;
        res_fire              = 1'b1;
        res_kind              = amg_pkg::KIND_EDGES;
        res_etotal            = keep;
        res_last              = (keep == '0);
        scan_next             = '0;
        edge_req.raddr        = '0;
        state_next            = (keep == '0) ? amg_pkg::ST_IDLE : amg_pkg::ST_EM_OUT;
      end

      amg_pkg::ST_EM_OUT: begin
        // one label per cycle, the next read issued alongside
        res_fire  = 1'b1;
        res_kind  = amg_pkg::KIND_LABEL;
        res_label = edge_rd_label;
        res_last  = scan_last;
        if (scan_last) begin
          state_next = amg_pkg::ST_IDLE;
        end else begin
          scan_next      = scan + amg_pkg::CNT_W'(1);
          edge_req.raddr = scan_next[amg_pkg::EIDX_W-1:0];
        end
      end

      default: begin
        state_next = amg_pkg::ST_IDLE;
      end
    endcase
  end

  // result register, unused fields come out as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      out_kind     <= res_kind;
      vertex_total <= res_vtotal;
      edge_total   <= res_etotal;
      out_label    <= res_label;
      last         <= res_last;
    end
  end

  assign kind      = out_kind;
  assign label_out = 64'(out_label);

  // a result only follows a taken item or work in progress
  a_strobe_cause: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy || start))
    else $error("result without a command in progress");

  // vertex count tracks the present bits
  a_vcount: assert property (@(posedge clk) disable iff (rst)
    32'(vcount) == $countones(present))
    else $error("vertex count out of step with present bits");

  a_ecount: assert property (@(posedge clk) disable iff (rst)
    32'(ecount) <= amg_pkg::EDGE_SLOTS)
    else $error("edge count beyond list size");

  // the final label of an erase frees the command port
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && last && (kind == amg_pkg::KIND_LABEL)) |-> !busy)
    else $error("still busy after final label");

endmodule

`default_nettype wire

### verif/adjacency_matrix_graph_store_core_test.sv
`timescale 1ns / 100ps

module adjacency_matrix_graph_store_core_test;

  // cycles with neither an item taken nor a result shown before giving up
  localparam int STALL_LIMIT = 2000;
  // drain time after the last result, longer than a full erase walk
  localparam int DRAIN_CYCLES = 120;
  localparam int ITEMS_PER_PHASE = 88;

  typedef struct {
    amg_pkg::kind_t kind;
    bit [6:0]       vertices;
    bit [5:0]       edges;
    bit [63:0]      label;
    bit             last;
  } graph_reply_t;

  typedef struct {
    amg_pkg::op_t op;
    bit [5:0]     a;
    bit [5:0]     b;
    bit [63:0]    label;
    bit           typed;
    graph_reply_t want;
  } graph_cmd_t;

  // all inputs start at known values before the first edge
  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  operation = '0;
  logic [5:0]  vertex_a = '0;
  logic [5:0]  vertex_b = '0;
  logic [63:0] edge_label = '0;
  logic        busy;
  logic        strobe;
  logic [1:0]  kind;
  logic [6:0]  vertex_total;
  logic [5:0]  edge_total;
  logic [63:0] label_out;
  logic        last;

  adjacency_matrix_graph_store_core dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .vertex_a(vertex_a),
    .vertex_b(vertex_b),
    .edge_label(edge_label),
    .strobe(strobe),
    .kind(kind),
    .vertex_total(vertex_total),
    .edge_total(edge_total),
    .label_out(label_out),
    .last(last)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // shadow copy of the graph, updated as each item is taken
  bit [63:0]   shadow_present;
  bit [63:0]   shadow_rows [64];
  bit [63:0]   shadow_labels [amg_pkg::EDGE_SLOTS];
  bit [5:0]    shadow_end_a [amg_pkg::EDGE_SLOTS];
  bit [5:0]    shadow_end_b [amg_pkg::EDGE_SLOTS];
  int unsigned shadow_vertices;
  int unsigned shadow_edges;

  graph_reply_t replies_due [$];
  graph_cmd_t   directed_cmds [$];
  int unsigned  fail_count;
  int unsigned  quiet_cycles;
  int unsigned  sender_idle_pct;
  bit [5:0]     vertex_pool_hi;

  function automatic graph_reply_t reply(amg_pkg::kind_t k, bit [6:0] v, bit [5:0] e,
                                         bit [63:0] lab, bit fin);
    graph_reply_t r;
    r.kind = k;
    r.vertices = v;
    r.edges = e;
    r.label = lab;
    r.last = fin;
    return r;
  endfunction

  // apply one item to the shadow graph and list the results it causes
  function automatic void apply_graph_op(input graph_cmd_t c,
                                         ref graph_reply_t out [$]);
    int unsigned keep;
    bit [5:0]    other;
    out.delete();
    case (c.op)
      amg_pkg::OP_INS_VERTEX: begin
        if (!shadow_present[c.a]) begin
          shadow_present[c.a] = 1'b1;
          shadow_vertices++;
        end
      end
      amg_pkg::OP_INS_EDGE: begin
        if (!shadow_present[c.a] || !shadow_present[c.b] ||
            shadow_rows[c.a][c.b] || shadow_edges >= amg_pkg::EDGE_SLOTS) begin
          out.insert(out.size(), reply(amg_pkg::KIND_ERROR, 0, 0, 0, 1'b1));
        end else begin
          shadow_rows[c.a][c.b] = 1'b1;
          shadow_rows[c.b][c.a] = 1'b1;
          shadow_labels[shadow_edges] = c.label;
          shadow_end_a[shadow_edges] = c.a;
          shadow_end_b[shadow_edges] = c.b;
          shadow_edges++;
        end
      end
      amg_pkg::OP_REPORT: begin
        out.insert(out.size(), reply(amg_pkg::KIND_COUNTS, 7'(shadow_vertices),
                                     6'(shadow_edges), 0, 1'b1));
      end
      default: begin
        if (!shadow_present[c.a]) begin
          out.insert(out.size(), reply(amg_pkg::KIND_ERROR, 0, 0, 0, 1'b1));
        end else begin
          // drop every edge touching the vertex, close up the survivors in order
          keep = 0;
          for (int i = 0; i < shadow_edges; i++) begin
            if (shadow_end_a[i] == c.a || shadow_end_b[i] == c.a) begin
              other = (shadow_end_a[i] == c.a) ? shadow_end_b[i] : shadow_end_a[i];
              shadow_rows[other][c.a] = 1'b0;
              shadow_rows[c.a][other] = 1'b0;
            end else begin
              shadow_labels[keep] = shadow_labels[i];
              shadow_end_a[keep] = shadow_end_a[i];
              shadow_end_b[keep] = shadow_end_b[i];
              keep++;
            end
          end
          shadow_edges = keep;
          shadow_rows[c.a] = '0;
          shadow_present[c.a] = 1'b0;
          shadow_vertices--;
          out.insert(out.size(), reply(amg_pkg::KIND_EDGES, 0, 6'(shadow_edges), 0,
                                       shadow_edges == 0));
          for (int i = 0; i < shadow_edges; i++)
            out.insert(out.size(), reply(amg_pkg::KIND_LABEL, 0, 0, shadow_labels[i],
                                         i + 1 == shadow_edges));
        end
      end
    endcase
  endfunction

  function automatic void add_cmd(amg_pkg::op_t op, bit [5:0] a, bit [5:0] b,
                                  bit [63:0] lab);
    graph_cmd_t c;
    c.op = op;
    c.a = a;
    c.b = b;
    c.label = lab;
    c.typed = 1'b0;
    c.want = reply(amg_pkg::KIND_ERROR, 0, 0, 0, 1'b0);
    directed_cmds.insert(directed_cmds.size(), c);
  endfunction

  // single-result rows whose answer is plain from the spec
  function automatic void add_cmd_typed(amg_pkg::op_t op, bit [5:0] a, bit [5:0] b,
                                        amg_pkg::kind_t k, bit [6:0] v, bit [5:0] e);
    add_cmd(op, a, b, '0);
    directed_cmds[directed_cmds.size() - 1].typed = 1'b1;
    directed_cmds[directed_cmds.size() - 1].want = reply(k, v, e, 0, 1'b1);
  endfunction

  // a present vertex if there is one, so most commands get past the checks
  function automatic bit [5:0] pick_vertex(bit want_present);
    int unsigned from;
    if (want_present && shadow_present != '0) begin
      from = $urandom_range(63);
      for (int i = 0; i < 64; i++)
        if (shadow_present[(from + i) % 64])
          return 6'((from + i) % 64);
    end
    return 6'($urandom_range(vertex_pool_hi));
  endfunction

  function automatic graph_cmd_t random_cmd();
    graph_cmd_t  c;
    int unsigned pick;
    pick = $urandom_range(99);
    c.typed = 1'b0;
    c.want = reply(amg_pkg::KIND_ERROR, 0, 0, 0, 1'b0);
    c.label = {$urandom, $urandom};
    c.b = 6'($urandom_range(63));
    if (pick < 12) begin
      // noise: anything the fields allow
      c.op = amg_pkg::op_t'($urandom_range(3));
      c.a = 6'($urandom_range(63));
    end else if (pick < 30) begin
      c.op = amg_pkg::OP_INS_VERTEX;
      c.a = pick_vertex(1'b0);
    end else if (pick < 78) begin
      c.op = amg_pkg::OP_INS_EDGE;
      c.a = pick_vertex($urandom_range(99) < 90);
      c.b = pick_vertex($urandom_range(99) < 90);
    end else if (pick < 90) begin
      c.op = amg_pkg::OP_ERASE;
      c.a = pick_vertex($urandom_range(99) < 80);
    end else begin
      c.op = amg_pkg::OP_REPORT;
      c.a = 6'($urandom_range(63));
    end
    return c;
  endfunction

  // present one item from a falling edge, hold it until taken, then predict
  task automatic issue_cmd(input graph_cmd_t c);
    graph_reply_t outs [$];
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    operation <= c.op;
    vertex_a <= c.a;
    vertex_b <= c.b;
    edge_label <= c.label;
    do @(posedge clk); while (busy !== 1'b0);
    apply_graph_op(c, outs);
    if (c.typed)
      replies_due.insert(replies_due.size(), c.want);
    else
      foreach (outs[i]) replies_due.insert(replies_due.size(), outs[i]);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // results cannot be held off, so every strobe is taken at once
  always @(posedge clk) begin : result_check
    graph_reply_t oldest;
    if (!rst && strobe === 1'b1) begin
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind %0d", $time, kind);
        fail_count++;
      end else begin
        oldest = replies_due.pop_front();
        check_field("kind", oldest.kind, kind);
        check_field("vertex_total", oldest.vertices, vertex_total);
        check_field("edge_total", oldest.edges, edge_total);
        check_field("label_out", oldest.label, label_out);
        check_field("last", oldest.last, last);
      end
    end
  end

  // watchdog: an item taken or a result shown counts as progress
  always @(posedge clk) begin
    if (rst || (start === 1'b1 && busy === 1'b0) || strobe === 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    fail_count = 0;
    sender_idle_pct = 0;
    vertex_pool_hi = 7;
    shadow_present = '0;
    foreach (shadow_rows[i]) shadow_rows[i] = '0;
    shadow_vertices = 0;
    shadow_edges = 0;

    // directed: empty store, errors, duplicates, self loops, vertex zero
    add_cmd_typed(amg_pkg::OP_REPORT, 0, 0, amg_pkg::KIND_COUNTS, 0, 0);
    add_cmd_typed(amg_pkg::OP_ERASE, 0, 0, amg_pkg::KIND_ERROR, 0, 0);
    add_cmd_typed(amg_pkg::OP_INS_EDGE, 0, 63, amg_pkg::KIND_ERROR, 0, 0);
    add_cmd(amg_pkg::OP_INS_VERTEX, 0, 0, '0);
    add_cmd(amg_pkg::OP_INS_VERTEX, 63, 63, '1);
    add_cmd(amg_pkg::OP_INS_VERTEX, 0, 0, '0);
    add_cmd_typed(amg_pkg::OP_REPORT, 63, 63, amg_pkg::KIND_COUNTS, 2, 0);
    add_cmd(amg_pkg::OP_INS_EDGE, 0, 63, '1);
    add_cmd_typed(amg_pkg::OP_INS_EDGE, 63, 0, amg_pkg::KIND_ERROR, 0, 0);
    add_cmd(amg_pkg::OP_INS_EDGE, 0, 0, '0);
    add_cmd(amg_pkg::OP_INS_VERTEX, 5, 0, '0);
    add_cmd(amg_pkg::OP_INS_EDGE, 5, 63, 64'h5555_5555_5555_5555);
    add_cmd(amg_pkg::OP_INS_EDGE, 63, 63, 64'haaaa_aaaa_aaaa_aaaa);
    add_cmd_typed(amg_pkg::OP_REPORT, 0, 0, amg_pkg::KIND_COUNTS, 3, 4);
    add_cmd(amg_pkg::OP_ERASE, 0, 0, '0);
    add_cmd_typed(amg_pkg::OP_INS_EDGE, 0, 5, amg_pkg::KIND_ERROR, 0, 0);
    add_cmd(amg_pkg::OP_ERASE, 5, 0, '0);
    // only the self loop on 63 is left, so the count alone closes it
    add_cmd_typed(amg_pkg::OP_ERASE, 63, 0, amg_pkg::KIND_EDGES, 0, 0);
    add_cmd_typed(amg_pkg::OP_REPORT, 0, 0, amg_pkg::KIND_COUNTS, 0, 0);
    add_cmd_typed(amg_pkg::OP_ERASE, 63, 0, amg_pkg::KIND_ERROR, 0, 0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_cmds[i]) issue_cmd(directed_cmds[i]);

    // random phases: no idling, sparse sender, steady, light idling
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  vertex_pool_hi = 7;  end
        1: begin sender_idle_pct = 86; vertex_pool_hi = 15; end
        2: begin sender_idle_pct = 0;  vertex_pool_hi = 63; end
        default: begin sender_idle_pct = 9; vertex_pool_hi = 7; end
      endcase
      repeat (ITEMS_PER_PHASE) issue_cmd(random_cmd());
    end
    start <= 1'b0;

    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

### adjacency_matrix_graph_store_core.f
src/amg_pkg.sv
src/amg_adj_mem.sv
src/amg_edge_mem.sv
src/adjacency_matrix_graph_store_core.sv
verif/adjacency_matrix_graph_store_core_test.sv
